FILE: hdl/hcbd_pkg.sv
// ----------------------------------------------------------------------------
// hcbd_pkg: shared types and constants for the chunked body decoder
// Item kinds, byte class record, result record, phase and error codes.
// ----------------------------------------------------------------------------
package hcbd_pkg;

	localparam logic [1:0] KIND_BYTE    = 2'd0;
	localparam logic [1:0] KIND_CLOSE   = 2'd1;
	localparam logic [1:0] KIND_RESTART = 2'd2;
	localparam logic [1:0] KIND_NOP     = 2'd3;

	localparam logic [2:0] ERR_CLOSED_SIZE    = 3'd0;
	localparam logic [2:0] ERR_INVALID_SIZE   = 3'd1;
	localparam logic [2:0] ERR_TOO_LARGE      = 3'd2;
	localparam logic [2:0] ERR_CLOSED_DATA    = 3'd3;
	localparam logic [2:0] ERR_MISSING_CRLF   = 3'd4;
	localparam logic [2:0] ERR_CLOSED_TRAILER = 3'd5;

	localparam logic [7:0] CHAR_CR   = 8'h0D;
	localparam logic [7:0] CHAR_LF   = 8'h0A;
	localparam logic [7:0] CHAR_SP   = 8'h20;
	localparam logic [7:0] CHAR_TAB  = 8'h09;
	localparam logic [7:0] CHAR_VT   = 8'h0B;
	localparam logic [7:0] CHAR_FF   = 8'h0C;

	localparam logic [31:0] MAX_BODY_RESET = 32'd1048576;

	// queue between front and back; depth must be a power of two
	localparam int QDEPTH = 2;
	localparam int QPTRW  = $clog2(QDEPTH);
	localparam int QCNTW  = $clog2(QDEPTH + 1);

	typedef enum logic [9:0] {
		PH_LEAD    = 10'b00_0000_0001,
		PH_DIGITS  = 10'b00_0000_0010,
		PH_TAIL    = 10'b00_0000_0100,
		PH_BAD     = 10'b00_0000_1000,
		PH_DATA    = 10'b00_0001_0000,
		PH_CR      = 10'b00_0010_0000,
		PH_LF      = 10'b00_0100_0000,
		PH_TRAILER = 10'b00_1000_0000,
		PH_DONE    = 10'b01_0000_0000,
		PH_FAILED  = 10'b10_0000_0000
	} phase_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic       is_hex;
		logic [3:0] hex_val;
		logic       is_blank;
		logic       is_cr;
		logic       is_lf;
	} item_t;

	typedef struct packed {
		logic       data_valid;
		logic [7:0] out_byte;
		logic       body_done;
		logic       error_valid;
		logic [2:0] error_code;
	} result_t;

	// queue handshake toward the back end
	typedef struct packed {
		logic  valid;
		item_t item;
	} qhead_t;

endpackage

FILE: hdl/hcbd_in_if.sv
// ----------------------------------------------------------------------------
// hcbd_in_if: input channel of the chunked body decoder
// Valid/ready transfer of one stream event (kind and byte).
// ----------------------------------------------------------------------------
interface hcbd_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] in_byte;

	modport source (output valid, output kind, output in_byte, input ready);
	modport sink (input valid, input kind, input in_byte, output ready);
endinterface

FILE: hdl/hcbd_out_if.sv
// ----------------------------------------------------------------------------
// hcbd_out_if: result channel of the chunked body decoder
// Valid/ready transfer of one result per input event.
// ----------------------------------------------------------------------------
interface hcbd_out_if;
	logic       valid;
	logic       ready;
	logic       data_valid;
	logic [7:0] out_byte;
	logic       body_done;
	logic       error_valid;
	logic [2:0] error_code;

	modport source (output valid, output data_valid, output out_byte, output body_done,
		output error_valid, output error_code, input ready);
	modport sink (input valid, input data_valid, input out_byte, input body_done,
		input error_valid, input error_code, output ready);
endinterface

FILE: hdl/hcbd_front.sv
// ----------------------------------------------------------------------------
// hcbd_front: input classifier and item queue
// Classifies each byte (hex digit, blank, CR, LF) and queues the record.
// ----------------------------------------------------------------------------
module hcbd_front import hcbd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] kind,
	input  logic [7:0] in_byte,
	output qhead_t     head,
	input  logic       pop
);

	item_t            cls;
	item_t            entry_q [QDEPTH];
	logic [QPTRW-1:0] wr_ptr_q;
	logic [QPTRW-1:0] rd_ptr_q;
	logic [QCNTW-1:0] count_q;
	logic             push;

	always_comb begin
		cls          = '0;
		cls.kind     = kind;
		cls.data     = in_byte;
		cls.is_cr    = (in_byte == CHAR_CR);
		cls.is_lf    = (in_byte == CHAR_LF);
		cls.is_blank = (in_byte == CHAR_SP) || (in_byte == CHAR_TAB) || (in_byte == CHAR_LF)
			|| (in_byte == CHAR_VT) || (in_byte == CHAR_FF) || (in_byte == CHAR_CR);
		if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
			cls.is_hex  = 1'b1;
			cls.hex_val = in_byte[3:0];
		end else if ((in_byte >= 8'h61 && in_byte <= 8'h66)
			|| (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
			cls.is_hex  = 1'b1;
			cls.hex_val = in_byte[3:0] + 4'd9;
		end
	end

	assign in_ready   = (count_q != QCNTW'(QDEPTH));
	assign push       = in_valid && in_ready;
	assign head.valid = (count_q != '0);
	assign head.item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("queue popped while empty");

endmodule

FILE: hdl/hcbd_back.sv
// ----------------------------------------------------------------------------
// hcbd_back: chunked body state machine and result register
// Parses size lines, passes data, checks CRLF, trailers and the body limit.
// ----------------------------------------------------------------------------
module hcbd_back import hcbd_pkg::*; #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [31:0] cfg_wdata,
	input  qhead_t      head,
	output logic        pop,
	output logic        res_valid,
	input  logic        res_ready,
	output result_t     res
);

	localparam int CMPW = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

	phase_t                 phase_q, phase_d;
	logic [COUNT_WIDTH-1:0] acc_q, acc_d;
	logic [COUNT_WIDTH-1:0] left_q, left_d;
	logic [31:0]            total_q, total_d;
	logic                   tle_q, tle_d;
	logic                   crp_q, crp_d;
	logic [31:0]            max_q;
	logic                   out_valid_q;
	result_t                out_q;
	result_t                nxt;
	item_t                  it;
	logic [31:0]            room;
	logic                   too_large;

	assign it        = head.item;
	assign room      = max_q - total_q;
	assign too_large = CMPW'(acc_q) > CMPW'(room);
	assign pop       = head.valid && (!out_valid_q || res_ready);
	assign res_valid = out_valid_q;
	assign res       = out_q;

	always_comb begin
		phase_d = phase_q;
		acc_d   = acc_q;
		left_d  = left_q;
		total_d = total_q;
		tle_d   = tle_q;
		crp_d   = crp_q;
		nxt     = '0;
		if (it.kind == KIND_RESTART) begin
			phase_d = PH_LEAD;
			acc_d   = '0;
			left_d  = '0;
			total_d = '0;
			tle_d   = 1'b1;
			crp_d   = 1'b0;
		end else if (it.kind == KIND_NOP || phase_q == PH_DONE || phase_q == PH_FAILED) begin
			// empty result, no state change
		end else if (it.kind == KIND_CLOSE) begin
			nxt.error_valid = 1'b1;
			phase_d         = PH_FAILED;
			if (phase_q == PH_LEAD || phase_q == PH_DIGITS || phase_q == PH_TAIL
				|| phase_q == PH_BAD) begin
				nxt.error_code = ERR_CLOSED_SIZE;
			end else if (phase_q == PH_TRAILER) begin
				nxt.error_code = ERR_CLOSED_TRAILER;
			end else begin
				nxt.error_code = ERR_CLOSED_DATA;
			end
		end else begin
			unique case (phase_q)
				PH_DATA: begin
					nxt.data_valid = 1'b1;
					nxt.out_byte   = it.data;
					total_d        = total_q + 32'd1;
					left_d         = left_q - COUNT_WIDTH'(1);
					if (left_q == COUNT_WIDTH'(1)) begin
						phase_d = PH_CR;
					end
				end
				PH_CR: begin
					if (it.is_cr) begin
						phase_d = PH_LF;
					end else begin
						nxt.error_valid = 1'b1;
						nxt.error_code  = ERR_MISSING_CRLF;
						phase_d         = PH_FAILED;
					end
				end
				PH_LF: begin
					if (it.is_lf) begin
						phase_d = PH_LEAD;
						crp_d   = 1'b0;
					end else begin
						nxt.error_valid = 1'b1;
						nxt.error_code  = ERR_MISSING_CRLF;
						phase_d         = PH_FAILED;
					end
				end
				PH_TRAILER: begin
					if (crp_q && it.is_lf) begin
						crp_d = 1'b0;
						tle_d = 1'b1;
						if (tle_q) begin
							nxt.body_done = 1'b1;
							phase_d       = PH_DONE;
						end
					end else begin
						crp_d = it.is_cr;
						if (crp_q || !it.is_cr) begin
							tle_d = 1'b0;
						end
					end
				end
				PH_LEAD, PH_DIGITS, PH_TAIL, PH_BAD: begin
					if (crp_q && it.is_lf) begin
						// end of size line
						crp_d = 1'b0;
						if (phase_q == PH_LEAD || phase_q == PH_BAD) begin
							nxt.error_valid = 1'b1;
							nxt.error_code  = ERR_INVALID_SIZE;
							phase_d         = PH_FAILED;
						end else begin
							acc_d = '0;
							if (acc_q == '0) begin
								phase_d = PH_TRAILER;
								tle_d   = 1'b1;
							end else if (too_large) begin
								nxt.error_valid = 1'b1;
								nxt.error_code  = ERR_TOO_LARGE;
								phase_d         = PH_FAILED;
							end else begin
								left_d  = acc_q;
								phase_d = PH_DATA;
							end
						end
					end else begin
						crp_d = it.is_cr;
						if (phase_q == PH_LEAD) begin
							if (it.is_hex) begin
								acc_d   = COUNT_WIDTH'(it.hex_val);
								phase_d = PH_DIGITS;
							end else if (!it.is_blank) begin
								phase_d = PH_BAD;
							end
						end else if (phase_q == PH_DIGITS) begin
							if (!it.is_hex) begin
								phase_d = PH_TAIL;
							end else if (acc_q[COUNT_WIDTH-1 -: 4] != 4'd0) begin
								phase_d = PH_BAD;
							end else begin
								acc_d = {acc_q[COUNT_WIDTH-5:0], it.hex_val};
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LEAD;
			acc_q       <= '0;
			left_q      <= '0;
			total_q     <= '0;
			tle_q       <= 1'b1;
			crp_q       <= 1'b0;
			max_q       <= MAX_BODY_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				max_q <= cfg_wdata;
			end
			if (pop) begin
				phase_q     <= phase_d;
				acc_q       <= acc_d;
				left_q      <= left_d;
				total_q     <= total_d;
				tle_q       <= tle_d;
				crp_q       <= crp_d;
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= nxt;
		end
	end

	a_data_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (left_q != '0))
		else $error("data phase with no bytes left");

	a_err_fails: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && nxt.error_valid) |=> (phase_q == PH_FAILED))
		else $error("error result without failed phase");

	a_total_step: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && nxt.data_valid) |=> (total_q == $past(total_q) + 32'd1))
		else $error("body total not advanced on data byte");

	a_one_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> $onehot0({out_q.data_valid, out_q.body_done, out_q.error_valid}))
		else $error("result carries more than one outcome");

endmodule

FILE: hdl/http_chunked_body_decoder_top.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_top: HTTP/1.1 chunked body decoder
// Byte-serial decode of chunk sizes, data, CRLF and trailers with body limit.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  in_ch     in   valid/ready    kind, in_byte
//  out_ch    out  valid/ready    data_valid, out_byte, body_done, error_valid, error_code
//  cfg       in   cfg_wen        cfg_wdata -> max_body_size
//
//  One item per cycle sustained while out_ch is ready; a result is presented once its
//  transfer has passed the queue entry and then the result register. The rate is set
//  by the phase update in the back end, made once per item. Reset clears the queue and
//  all decode state and loads max_body_size with 1048576. A stalled out_ch holds the
//  result register; the two-entry queue keeps taking items until it fills, then
//  in_ch.ready drops.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_top import hcbd_pkg::*; #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [31:0] cfg_wdata,
	hcbd_in_if.sink     in_ch,
	hcbd_out_if.source  out_ch
);

	qhead_t  head;
	logic    pop;
	result_t res;

	hcbd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.kind     (in_ch.kind),
		.in_byte  (in_ch.in_byte),
		.head     (head),
		.pop      (pop)
	);

	hcbd_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.head      (head),
		.pop       (pop),
		.res_valid (out_ch.valid),
		.res_ready (out_ch.ready),
		.res       (res)
	);

	assign out_ch.data_valid  = res.data_valid;
	assign out_ch.out_byte    = res.out_byte;
	assign out_ch.body_done   = res.body_done;
	assign out_ch.error_valid = res.error_valid;
	assign out_ch.error_code  = res.error_code;

endmodule
